[sv/ptrt_pkg.sv]
// ptrt_pkg: shared constants, codes and controller/datapath handshake types
// for the periodic task release table.
// No dependencies; compiled first.
package ptrt_pkg;

    // Table sizing and field widths
    localparam int MAX_TASKS_DEF = 8;
    localparam int RESULT_LIMIT  = 8;
    localparam int FIRE_W        = $clog2(RESULT_LIMIT + 1);
    localparam int MODE_W        = 2;
    localparam int ID_W          = 8;
    localparam int PERIOD_W      = 16;
    localparam int BASE_W        = 8;
    localparam int COUNT_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = ID_W + PERIOD_W;

    // Shared divider: 32-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DVD_W  = COUNT_W;
    localparam int DSR_W  = PERIOD_W;
    localparam int STEP_W = $clog2(DVD_W);

    localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;

    typedef logic [3:0] active_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_UPDATE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DIV_BASE,
        S_DIV_START,
        S_DIV_CNT,
        S_FIRE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TICK_END,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_NEXT,
        ADDR_TOTAL
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ITEM,
        WD_UPDATE,
        WD_COPY
    } wd_sel_t;

    typedef enum logic {
        DIV_BASE,
        DIV_COUNT
    } div_sel_t;

    typedef enum logic [1:0] {
        OUT_FIRE,
        OUT_TICK_END,
        OUT_DONE
    } out_kind_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load_item;
        logic      ram_rd;
        logic      ram_we;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        logic      total_inc;
        logic      total_dec;
        logic      idx_inc;
        logic      div_start;
        div_sel_t  div_sel;
        logic      div_latch;
        logic      pend_load;
        logic      status_load;
        status_t   status_val;
        logic      out_load;
        out_kind_t out_kind;
        logic      counter_inc;
    } ptrt_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  idx_end;
        logic  idx_last;
        logic  full;
        logic  id_match;
        logic  div_done;
        logic  rem_zero;
        logic  fire_full;
        logic  pend_valid;
        logic  out_free;
    } ptrt_stat_t;

endpackage

[sv/ptrt_in_if.sv]
// ptrt_in_if: valid/ready channel carrying one table item (mode, id, period).
// Depends on ptrt_pkg for field widths.
interface ptrt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptrt_pkg::MODE_W-1:0]   mode;
    logic [ptrt_pkg::ID_W-1:0]     task_id;
    logic [ptrt_pkg::PERIOD_W-1:0] period_ms;

    modport source (output valid, output mode, output task_id, output period_ms,
                    input ready);
    modport sink   (input valid, input mode, input task_id, input period_ms,
                    output ready);
endinterface

[sv/ptrt_out_if.sv]
// ptrt_out_if: valid/ready channel carrying one result of the release table.
// Depends on ptrt_pkg for field widths.
interface ptrt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptrt_pkg::ID_W-1:0]     fired_task;
    logic                          fired;
    logic [ptrt_pkg::STATUS_W-1:0] status;
    logic [ptrt_pkg::COUNT_W-1:0]  tick_count;
    ptrt_pkg::active_t             active_tasks;
    logic                          last;

    modport source (output valid, output fired_task, output fired, output status,
                    output tick_count, output active_tasks, output last,
                    input ready);
    modport sink   (input valid, input fired_task, input fired, input status,
                    input tick_count, input active_tasks, input last,
                    output ready);
endinterface

[sv/ptrt_ram.sv]
// ptrt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptrt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ptrt_div.sv]
// ptrt_div: restoring divider, one quotient bit per cycle.
// Depends on ptrt_pkg for operand widths. Divisor must be nonzero.
module ptrt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptrt_pkg::DVD_W-1:0] dividend,
    input  logic [ptrt_pkg::DSR_W-1:0] divisor,
    output logic                       done,
    output logic [ptrt_pkg::DVD_W-1:0] quotient,
    output logic [ptrt_pkg::DSR_W-1:0] remainder
);

    localparam int DVD_W  = ptrt_pkg::DVD_W;
    localparam int DSR_W  = ptrt_pkg::DSR_W;
    localparam int STEP_W = ptrt_pkg::STEP_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;

    logic [DSR_W:0]    rem_sh;
    logic [DSR_W:0]    diff;
    logic              q_bit;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        q_bit  = ~diff[DSR_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

[sv/ptrt_dp.sv]
// ptrt_dp: datapath of the release table: item latch, table RAM, counters,
// shared divider, pending release and output register.
// Depends on ptrt_pkg, ptrt_ram, ptrt_div.
module ptrt_dp #(
    parameter int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ptrt_pkg::MODE_W-1:0]   in_mode,
    input  logic [ptrt_pkg::ID_W-1:0]     in_task_id,
    input  logic [ptrt_pkg::PERIOD_W-1:0] in_period_ms,
    input  logic                          cfg_wr_en,
    input  logic [ptrt_pkg::BASE_W-1:0]   cfg_wr_data,
    input  ptrt_pkg::ptrt_cmd_t           cmd,
    output ptrt_pkg::ptrt_stat_t          stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ptrt_pkg::ID_W-1:0]     out_fired_task,
    output logic                          out_fired,
    output ptrt_pkg::status_t             out_status,
    output logic [ptrt_pkg::COUNT_W-1:0]  out_tick_count,
    output ptrt_pkg::active_t             out_active_tasks,
    output logic                          out_last
);

    localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W    = $clog2(MAX_TASKS + 1);
    localparam int ID_W     = ptrt_pkg::ID_W;
    localparam int PERIOD_W = ptrt_pkg::PERIOD_W;
    localparam int BASE_W   = ptrt_pkg::BASE_W;
    localparam int COUNT_W  = ptrt_pkg::COUNT_W;
    localparam int ENTRY_W  = ptrt_pkg::ENTRY_W;
    localparam int FIRE_W   = ptrt_pkg::FIRE_W;
    localparam logic [CNT_W-1:0]  TOTAL_MAX  = CNT_W'(MAX_TASKS);
    localparam logic [FIRE_W-1:0] FIRE_LIMIT = FIRE_W'(ptrt_pkg::RESULT_LIMIT);

    // item latch (payload)
    ptrt_pkg::mode_t     mode_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PERIOD_W-1:0] period_reg;

    // control state
    logic [BASE_W-1:0]   base_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic [COUNT_W-1:0]  counter_reg;
    ptrt_pkg::status_t   st_reg;
    logic                pend_valid_reg;
    logic [FIRE_W-1:0]   nfire_reg;
    logic                out_valid_reg;

    // payload state
    logic [ID_W-1:0]     pend_id_reg;
    logic [PERIOD_W-1:0] div_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic                out_fired_reg;
    ptrt_pkg::status_t   out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    ptrt_pkg::active_t   out_active_reg;
    logic                out_last_reg;

    // table RAM and divider wiring
    logic [IDX_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ID_W-1:0]     rd_id;
    logic [PERIOD_W-1:0] rd_period;
    logic [CNT_W-1:0]    idx_plus1;
    logic [BASE_W-1:0]   base_eff;
    logic [COUNT_W-1:0]  div_dividend;
    logic [PERIOD_W-1:0] div_divisor;
    logic                div_done;
    logic [COUNT_W-1:0]  div_quotient;
    logic [PERIOD_W-1:0] div_remainder;
    logic                out_free;

    assign rd_id     = ram_rdata[ENTRY_W-1 -: ID_W];
    assign rd_period = ram_rdata[PERIOD_W-1:0];
    assign idx_plus1 = idx_reg + 1'b1;
    assign base_eff  = (base_reg == '0) ? BASE_W'(1) : base_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // table address and write data select
    always_comb
    begin
        unique case (cmd.addr_sel)
            ptrt_pkg::ADDR_IDX:   ram_addr = idx_reg[IDX_W-1:0];
            ptrt_pkg::ADDR_NEXT:  ram_addr = idx_plus1[IDX_W-1:0];
            ptrt_pkg::ADDR_TOTAL: ram_addr = total_reg[IDX_W-1:0];
            default:              ram_addr = idx_reg[IDX_W-1:0];
        endcase
        unique case (cmd.wd_sel)
            ptrt_pkg::WD_ITEM:   ram_wdata = {id_reg, period_reg};
            ptrt_pkg::WD_UPDATE: ram_wdata = {rd_id, period_reg};
            ptrt_pkg::WD_COPY:   ram_wdata = ram_rdata;
            default:             ram_wdata = {id_reg, period_reg};
        endcase
    end

    ptrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.ram_we),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    // divider operands: period / base, then counter % divisor
    always_comb
    begin
        if (cmd.div_sel == ptrt_pkg::DIV_BASE)
        begin
            div_dividend = COUNT_W'(rd_period);
            div_divisor  = PERIOD_W'(base_eff);
        end
        else
        begin
            div_dividend = counter_reg;
            div_divisor  = div_reg;
        end
    end

    ptrt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // counter next values
    always_comb
    begin
        total_next = total_reg;
        if (cmd.total_inc)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (cmd.total_dec)
        begin
            total_next = total_reg - 1'b1;
        end
        idx_next = idx_reg;
        if (cmd.load_item)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= ptrt_pkg::BASE_RESET;
            total_reg      <= '0;
            idx_reg        <= '0;
            counter_reg    <= ptrt_pkg::COUNT_RESET;
            st_reg         <= ptrt_pkg::ST_OK;
            pend_valid_reg <= 1'b0;
            nfire_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            total_reg <= total_next;
            idx_reg   <= idx_next;
            if (cmd.counter_inc)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (cmd.load_item)
            begin
                st_reg         <= ptrt_pkg::ST_OK;
                pend_valid_reg <= 1'b0;
                nfire_reg      <= '0;
            end
            else
            begin
                if (cmd.status_load)
                begin
                    st_reg <= cmd.status_val;
                end
                if (cmd.pend_load)
                begin
                    pend_valid_reg <= 1'b1;
                    nfire_reg      <= nfire_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item latch, divisor, pending release, output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg   <= ptrt_pkg::mode_t'(in_mode);
            id_reg     <= in_task_id;
            period_reg <= in_period_ms;
        end
        if (cmd.div_latch)
        begin
            div_reg <= (div_quotient[PERIOD_W-1:0] == '0) ? PERIOD_W'(1)
                                                         : div_quotient[PERIOD_W-1:0];
        end
        if (cmd.pend_load)
        begin
            pend_id_reg <= rd_id;
        end
        if (cmd.out_load)
        begin
            out_count_reg  <= counter_reg;
            out_active_reg <= ptrt_pkg::active_t'(total_reg);
            unique case (cmd.out_kind)
                ptrt_pkg::OUT_FIRE:
                begin
                    out_id_reg     <= pend_id_reg;
                    out_fired_reg  <= 1'b1;
                    out_status_reg <= ptrt_pkg::ST_OK;
                    out_last_reg   <= 1'b0;
                end
                ptrt_pkg::OUT_TICK_END:
                begin
                    out_id_reg     <= pend_valid_reg ? pend_id_reg : '0;
                    out_fired_reg  <= pend_valid_reg;
                    out_status_reg <= ptrt_pkg::ST_OK;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_id_reg     <= '0;
                    out_fired_reg  <= 1'b0;
                    out_status_reg <= st_reg;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    // status to controller
    always_comb
    begin
        stat.mode       = mode_reg;
        stat.idx_end    = (idx_reg >= total_reg);
        stat.idx_last   = (idx_plus1 >= total_reg);
        stat.full       = (total_reg >= TOTAL_MAX);
        stat.id_match   = (rd_id == id_reg);
        stat.div_done   = div_done;
        stat.rem_zero   = (div_remainder == '0);
        stat.fire_full  = (nfire_reg >= FIRE_LIMIT);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    assign out_valid        = out_valid_reg;
    assign out_fired_task   = out_id_reg;
    assign out_fired        = out_fired_reg;
    assign out_status       = out_status_reg;
    assign out_tick_count   = out_count_reg;
    assign out_active_tasks = out_active_reg;
    assign out_last         = out_last_reg;

endmodule

[sv/ptrt_ctrl.sv]
// ptrt_ctrl: controller state machine of the release table; sequences table
// scans, divider runs, entry shifts and result transfers.
// Depends on ptrt_pkg.
module ptrt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptrt_pkg::ptrt_stat_t stat,
    output ptrt_pkg::ptrt_cmd_t  cmd
);

    ptrt_pkg::state_t state_reg;
    ptrt_pkg::state_t state_next;
    logic             is_tick;

    assign is_tick = (stat.mode == ptrt_pkg::MODE_TICK);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptrt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptrt_pkg::S_DISPATCH;
                end
            end
            ptrt_pkg::S_DISPATCH:
            begin
                if (stat.mode == ptrt_pkg::MODE_ADD)
                begin
                    state_next = ptrt_pkg::S_DONE;
                end
                else
                begin
                    state_next = ptrt_pkg::S_SCAN_RD;
                end
            end
            ptrt_pkg::S_SCAN_RD:
            begin
                if (!stat.idx_end)
                begin
                    state_next = ptrt_pkg::S_SCAN_CMP;
                end
                else if (is_tick)
                begin
                    state_next = ptrt_pkg::S_TICK_END;
                end
                else
                begin
                    state_next = ptrt_pkg::S_DONE;
                end
            end
            ptrt_pkg::S_SCAN_CMP:
            begin
                if (is_tick)
                begin
                    state_next = ptrt_pkg::S_DIV_BASE;
                end
                else if (!stat.id_match)
                begin
                    state_next = ptrt_pkg::S_SCAN_RD;
                end
                else if (stat.mode == ptrt_pkg::MODE_REMOVE)
                begin
                    state_next = ptrt_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = ptrt_pkg::S_DONE;
                end
            end
            ptrt_pkg::S_DIV_BASE:
            begin
                if (stat.div_done)
                begin
                    state_next = ptrt_pkg::S_DIV_START;
                end
            end
            ptrt_pkg::S_DIV_START:
            begin
                state_next = ptrt_pkg::S_DIV_CNT;
            end
            ptrt_pkg::S_DIV_CNT:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero && !stat.fire_full)
                    begin
                        state_next = ptrt_pkg::S_FIRE;
                    end
                    else
                    begin
                        state_next = ptrt_pkg::S_SCAN_RD;
                    end
                end
            end
            ptrt_pkg::S_FIRE:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = ptrt_pkg::S_SCAN_RD;
                end
            end
            ptrt_pkg::S_SHIFT_RD:
            begin
                if (stat.idx_last)
                begin
                    state_next = ptrt_pkg::S_DONE;
                end
                else
                begin
                    state_next = ptrt_pkg::S_SHIFT_WR;
                end
            end
            ptrt_pkg::S_SHIFT_WR:
            begin
                state_next = ptrt_pkg::S_SHIFT_RD;
            end
            ptrt_pkg::S_TICK_END,
            ptrt_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ptrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptrt_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ptrt_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ptrt_pkg::S_DISPATCH:
            begin
                if (stat.mode == ptrt_pkg::MODE_ADD)
                begin
                    if (stat.full)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = ptrt_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ram_we    = 1'b1;
                        cmd.addr_sel  = ptrt_pkg::ADDR_TOTAL;
                        cmd.wd_sel    = ptrt_pkg::WD_ITEM;
                        cmd.total_inc = 1'b1;
                    end
                end
            end
            ptrt_pkg::S_SCAN_RD:
            begin
                if (!stat.idx_end)
                begin
                    cmd.ram_rd   = 1'b1;
                    cmd.addr_sel = ptrt_pkg::ADDR_IDX;
                end
                else if (!is_tick)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = ptrt_pkg::ST_NOT_FOUND;
                end
            end
            ptrt_pkg::S_SCAN_CMP:
            begin
                if (is_tick)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ptrt_pkg::DIV_BASE;
                end
                else if (!stat.id_match)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (stat.mode == ptrt_pkg::MODE_UPDATE)
                begin
                    cmd.ram_we   = 1'b1;
                    cmd.addr_sel = ptrt_pkg::ADDR_IDX;
                    cmd.wd_sel   = ptrt_pkg::WD_UPDATE;
                end
            end
            ptrt_pkg::S_DIV_BASE:
            begin
                cmd.div_latch = stat.div_done;
            end
            ptrt_pkg::S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ptrt_pkg::DIV_COUNT;
            end
            ptrt_pkg::S_DIV_CNT:
            begin
                cmd.div_sel = ptrt_pkg::DIV_COUNT;
                cmd.idx_inc = stat.div_done && !(stat.rem_zero && !stat.fire_full);
            end
            ptrt_pkg::S_FIRE:
            begin
                // earlier pending release, if any, goes out; this one becomes pending
                if (!stat.pend_valid)
                begin
                    cmd.pend_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = ptrt_pkg::OUT_FIRE;
                    cmd.pend_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            ptrt_pkg::S_SHIFT_RD:
            begin
                if (stat.idx_last)
                begin
                    cmd.total_dec = 1'b1;
                end
                else
                begin
                    cmd.ram_rd   = 1'b1;
                    cmd.addr_sel = ptrt_pkg::ADDR_NEXT;
                end
            end
            ptrt_pkg::S_SHIFT_WR:
            begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ptrt_pkg::ADDR_IDX;
                cmd.wd_sel   = ptrt_pkg::WD_COPY;
                cmd.idx_inc  = 1'b1;
            end
            ptrt_pkg::S_TICK_END:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = ptrt_pkg::OUT_TICK_END;
                    cmd.counter_inc = 1'b1;
                end
            end
            ptrt_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ptrt_pkg::OUT_DONE;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/periodic_task_release_table_unit.sv]
// periodic_task_release_table_unit: top level of the periodic task release table.
// Depends on ptrt_pkg, ptrt_in_if, ptrt_out_if, ptrt_ctrl, ptrt_dp.
//
// Takes one item at a time. Add writes the entry at the end of the table; remove
// and update read and compare each entry scanned, remove then reads and writes
// each entry moved up to close the gap. A tick visits every entry: the single
// shared divider retires one bit per cycle and runs twice per entry (period /
// base, then counter % divisor), and a tick may also wait on the result side.
// A result sits in an output register; a new item is taken as soon as the
// last result of the previous one has been loaded there. No clearing pass:
// the table RAM is only read below the entry count.
module periodic_task_release_table_unit #(
    parameter int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ptrt_pkg::BASE_W-1:0] cfg_wr_data,
    ptrt_in_if.sink                     in_ch,
    ptrt_out_if.source                  out_ch
);

    ptrt_pkg::ptrt_cmd_t  cmd;
    ptrt_pkg::ptrt_stat_t stat;
    ptrt_pkg::status_t    out_status;

    // control
    ptrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    ptrt_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_mode          (in_ch.mode),
        .in_task_id       (in_ch.task_id),
        .in_period_ms     (in_ch.period_ms),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_fired_task   (out_ch.fired_task),
        .out_fired        (out_ch.fired),
        .out_status       (out_status),
        .out_tick_count   (out_ch.tick_count),
        .out_active_tasks (out_ch.active_tasks),
        .out_last         (out_ch.last)
    );

    assign out_ch.status = out_status;

endmodule

[sv/ptrt_chk.sv]
// ptrt_chk: port-level checks for the release table, bound to the top level.
// Depends on ptrt_pkg and periodic_task_release_table_unit.
module ptrt_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [ptrt_pkg::ID_W-1:0]     out_fired_task,
    input logic                          out_fired,
    input logic [ptrt_pkg::STATUS_W-1:0] out_status,
    input logic [ptrt_pkg::COUNT_W-1:0]  out_tick_count,
    input ptrt_pkg::active_t             out_active_tasks,
    input logic                          out_last
);

    // stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_fired_task)
            && $stable(out_fired) && $stable(out_status)
            && $stable(out_tick_count) && $stable(out_active_tasks) && $stable(out_last))
        else $error("result changed while stalled");

    // one item in flight: no back-to-back transfer on the input
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in work");

    // a result without a release carries no id and closes its item
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_fired |-> out_fired_task == '0 && out_last)
        else $error("non-release result malformed");

    // releases only come from ticks, which always report ok
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_fired |-> out_status == ptrt_pkg::ST_OK)
        else $error("release with error status");

endmodule

bind periodic_task_release_table_unit ptrt_chk u_ptrt_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_fired_task   (out_ch.fired_task),
    .out_fired        (out_ch.fired),
    .out_status       (out_ch.status),
    .out_tick_count   (out_ch.tick_count),
    .out_active_tasks (out_ch.active_tasks),
    .out_last         (out_ch.last)
);

[test/periodic_task_release_table_unit_tb.sv]
// Testbench for periodic_task_release_table_unit: directed and random table items,
// an in-bench predictor of the release table, and in-order checks of every result.
// Depends on ptrt_pkg, ptrt_in_if, ptrt_out_if and the unit under test.
`timescale 1ns / 100ps

module periodic_task_release_table_unit_tb;

    localparam int          RESET_CYCLES  = 5;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 600;
    localparam int unsigned CYCLE_LIMIT   = 1_200_000;
    localparam int          PHASE_ITEMS   = 60;
    localparam int          NUM_PHASES    = 5;
    localparam int          REPORT_MAX    = 10;

    localparam int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF;
    localparam int ID_W      = ptrt_pkg::ID_W;
    localparam int PERIOD_W  = ptrt_pkg::PERIOD_W;
    localparam int BASE_W    = ptrt_pkg::BASE_W;
    localparam int COUNT_W   = ptrt_pkg::COUNT_W;

    typedef struct packed {
        ptrt_pkg::mode_t     mode;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period_ms;
    } table_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    fired_task;
        logic               fired;
        ptrt_pkg::status_t  status;
        logic [COUNT_W-1:0] tick_count;
        ptrt_pkg::active_t  active_tasks;
        logic               last;
    } release_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [BASE_W-1:0] cfg_wr_data;

    ptrt_in_if  in_ch ();
    ptrt_out_if out_ch ();

    periodic_task_release_table_unit #(
        .MAX_TASKS(MAX_TASKS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // Shadow copy of the task table, tick counter and base period
    logic [ID_W-1:0]     tbl_id     [MAX_TASKS];
    logic [PERIOD_W-1:0] tbl_period [MAX_TASKS];
    int                  tbl_count;
    logic [COUNT_W-1:0]  tick_now;
    logic [BASE_W-1:0]   base_ms;

    table_cmd_t  cmd_queue[$];
    release_t    release_queue[$];
    table_cmd_t  next_cmd;
    int          mismatches;
    bit          quiet_run;
    logic [BASE_W-1:0] gen_base;
    int unsigned cycle_count = 0;
    int unsigned send_gap;
    int unsigned recv_hold;

    always #2 clk = ~clk;

    // First matching id in table order, -1 if none
    function automatic int find_task(logic [ID_W-1:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // Apply one accepted item to the shadow table and queue the results it releases
    function automatic void predict_cmd(table_cmd_t c);
        release_t            fires[$];
        release_t            r;
        int                  pos;
        logic [PERIOD_W-1:0] div;
        logic [BASE_W-1:0]   b;
        ptrt_pkg::status_t   st;
        r = '0;
        r.tick_count = tick_now;
        st = ptrt_pkg::ST_OK;
        if (c.mode == ptrt_pkg::MODE_TICK)
        begin
            b = (base_ms == '0) ? BASE_W'(1) : base_ms;
            for (int i = 0; i < tbl_count; i++)
            begin
                div = tbl_period[i] / PERIOD_W'(b);
                if (div == '0)
                    div = PERIOD_W'(1);
                if ((tick_now % COUNT_W'(div)) == '0 &&
                    fires.size() < ptrt_pkg::RESULT_LIMIT)
                begin
                    r.fired_task = tbl_id[i];
                    r.fired = 1'b1;
                    r.active_tasks = ptrt_pkg::active_t'(tbl_count);
                    r.last = 1'b0;
                    fires.push_back(r);
                end
            end
            if (fires.size() == 0)
            begin
                // tick with no release still yields one result
                r.active_tasks = ptrt_pkg::active_t'(tbl_count);
                r.last = 1'b1;
                fires.push_back(r);
            end
            else
            begin
                fires[fires.size()-1].last = 1'b1;
            end
            foreach (fires[i])
                release_queue.push_back(fires[i]);
            tick_now = tick_now + 1'b1;
        end
        else
        begin
            case (c.mode)
                ptrt_pkg::MODE_ADD:
                begin
                    if (tbl_count >= MAX_TASKS)
                    begin
                        st = ptrt_pkg::ST_FULL;
                    end
                    else
                    begin
                        tbl_id[tbl_count] = c.task_id;
                        tbl_period[tbl_count] = c.period_ms;
                        tbl_count++;
                    end
                end
                ptrt_pkg::MODE_REMOVE:
                begin
                    pos = find_task(c.task_id);
                    if (pos < 0)
                    begin
                        st = ptrt_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        // close the gap
                        for (int i = pos; i + 1 < tbl_count; i++)
                        begin
                            tbl_id[i] = tbl_id[i+1];
                            tbl_period[i] = tbl_period[i+1];
                        end
                        tbl_count--;
                    end
                end
                default:
                begin
                    pos = find_task(c.task_id);
                    if (pos < 0)
                        st = ptrt_pkg::ST_NOT_FOUND;
                    else
                        tbl_period[pos] = c.period_ms;
                end
            endcase
            r.status = st;
            r.active_tasks = ptrt_pkg::active_t'(tbl_count);
            r.last = 1'b1;
            release_queue.push_back(r);
        end
    endfunction

    // Compare one result transfer against the oldest expectation
    function automatic void compare_release(release_t got);
        release_t want;
        bit       ok;
        if (release_queue.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result: task %0d fired %0b status %0d tick %0d %s",
                         got.fired_task, got.fired, got.status, got.tick_count,
                         $sformatf("active %0d last %0b", got.active_tasks, got.last));
            return;
        end
        want = release_queue.pop_front();
        ok = (got.fired_task === want.fired_task) && (got.fired === want.fired) &&
             (got.status === want.status) && (got.tick_count === want.tick_count) &&
             (got.active_tasks === want.active_tasks) && (got.last === want.last);
        if (!ok)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("mismatch exp: task %0d fired %0b status %0d tick %0d %s",
                         want.fired_task, want.fired, want.status, want.tick_count,
                         $sformatf("active %0d last %0b", want.active_tasks, want.last));
                $display("         act: task %0d fired %0b status %0d tick %0d %s",
                         got.fired_task, got.fired, got.status, got.tick_count,
                         $sformatf("active %0d last %0b", got.active_tasks, got.last));
            end
        end
    endfunction

    // Random item: mostly a small id pool so remove/update hit, periods near the base
    function automatic table_cmd_t gen_cmd(int add_pct);
        table_cmd_t        c;
        int unsigned       r;
        int unsigned       s;
        logic [BASE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 40)
            c.mode = ptrt_pkg::MODE_TICK;
        else if (r < 40 + add_pct)
            c.mode = ptrt_pkg::MODE_ADD;
        else if (r[0])
            c.mode = ptrt_pkg::MODE_REMOVE;
        else
            c.mode = ptrt_pkg::MODE_UPDATE;
        c.task_id = ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 7))
                                                : ID_W'($urandom_range(0, 255));
        b = (gen_base == '0) ? BASE_W'(1) : gen_base;
        s = $urandom_range(0, 9);
        if (s < 5)
            c.period_ms = PERIOD_W'(b * $urandom_range(0, 8));
        else if (s < 7)
            c.period_ms = PERIOD_W'($urandom_range(0, b - 1'b1));
        else
            c.period_ms = PERIOD_W'($urandom_range(0, 65535));
        return c;
    endfunction

    task automatic push_cmd(ptrt_pkg::mode_t m, logic [ID_W-1:0] id,
                            logic [PERIOD_W-1:0] p);
        table_cmd_t c;
        c.mode = m;
        c.task_id = id;
        c.period_ms = p;
        cmd_queue.push_back(c);
    endtask

    // Wait until every item is taken and every result has arrived
    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || in_ch.valid || release_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(logic [BASE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        base_ms = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: feeds items from cmd_queue, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.mode <= ptrt_pkg::MODE_TICK;
            in_ch.task_id <= '0;
            in_ch.period_ms <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_cmd(table_cmd_t'{ptrt_pkg::mode_t'(in_ch.mode), in_ch.task_id,
                                         in_ch.period_ms});
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0 && !quiet_run && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    next_cmd = cmd_queue.pop_front();
                    in_ch.mode <= next_cmd.mode;
                    in_ch.task_id <= next_cmd.task_id;
                    in_ch.period_ms <= next_cmd.period_ms;
                    in_ch.valid <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer, stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                compare_release(release_t'{out_ch.fired_task, out_ch.fired,
                                           ptrt_pkg::status_t'(out_ch.status),
                                           out_ch.tick_count, out_ch.active_tasks,
                                           out_ch.last});
            end
            if (recv_hold != 0)
            begin
                recv_hold <= recv_hold - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet_run && $urandom_range(0, 4) == 0)
            begin
                recv_hold <= $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[periodic_task_release_table_unit] ERROR");
            $finish;
        end
    end

    // Sequencer: reset, directed items, then random phases over several base periods
    initial
    begin
        logic [BASE_W-1:0] phase_base [NUM_PHASES];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = ptrt_pkg::BASE_RESET;
        in_ch.valid = 1'b0;
        in_ch.mode = ptrt_pkg::MODE_TICK;
        in_ch.task_id = '0;
        in_ch.period_ms = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        quiet_run = 1'b0;
        tbl_count = 0;
        tick_now = ptrt_pkg::COUNT_RESET;
        base_ms = ptrt_pkg::BASE_RESET;
        gen_base = ptrt_pkg::BASE_RESET;
        foreach (tbl_id[i])
        begin
            tbl_id[i] = '0;
            tbl_period[i] = '0;
        end
        phase_base[0] = 8'd1;
        phase_base[1] = 8'd255;
        phase_base[2] = 8'd0;
        phase_base[3] = BASE_W'($urandom_range(2, 254));
        phase_base[4] = ptrt_pkg::BASE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset base period
        push_cmd(ptrt_pkg::MODE_TICK, 8'd0, 16'd0);          // tick on an empty table
        push_cmd(ptrt_pkg::MODE_UPDATE, 8'd5, 16'd100);      // unknown id
        push_cmd(ptrt_pkg::MODE_REMOVE, 8'd5, 16'd0);        // unknown id
        push_cmd(ptrt_pkg::MODE_ADD, 8'd0, 16'd0);           // divisor rounds to zero
        push_cmd(ptrt_pkg::MODE_ADD, 8'd255, 16'hFFFF);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd7, 16'd20);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd7, 16'd30);          // duplicate id
        push_cmd(ptrt_pkg::MODE_TICK, 8'hFF, 16'hFFFF);
        push_cmd(ptrt_pkg::MODE_UPDATE, 8'd7, 16'd9);        // first match only
        push_cmd(ptrt_pkg::MODE_TICK, 8'd0, 16'd0);
        push_cmd(ptrt_pkg::MODE_REMOVE, 8'd7, 16'd0);        // first match only
        push_cmd(ptrt_pkg::MODE_ADD, 8'd1, 16'd10);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd2, 16'd40);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd3, 16'd50);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd4, 16'd60);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd5, 16'd70);
        push_cmd(ptrt_pkg::MODE_ADD, 8'd9, 16'd10);          // table full
        push_cmd(ptrt_pkg::MODE_TICK, 8'd0, 16'd0);
        push_cmd(ptrt_pkg::MODE_REMOVE, 8'd0, 16'd0);        // head entry
        push_cmd(ptrt_pkg::MODE_REMOVE, 8'd5, 16'd0);        // tail entry
        push_cmd(ptrt_pkg::MODE_UPDATE, 8'd255, 16'd10);
        push_cmd(ptrt_pkg::MODE_TICK, 8'd0, 16'd0);
        push_cmd(ptrt_pkg::MODE_TICK, 8'd0, 16'd0);
        wait_idle();

        // Random phases; the last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_base(phase_base[p]);
            gen_base = phase_base[p];
            if (p == NUM_PHASES - 1)
                quiet_run = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                cmd_queue.push_back(gen_cmd((k < PHASE_ITEMS / 2) ? 35 : 12));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && release_queue.size() == 0)
            $display("[periodic_task_release_table_unit] OK");
        else
            $display("[periodic_task_release_table_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/ptrt_pkg.sv
sv/ptrt_in_if.sv
sv/ptrt_out_if.sv
sv/ptrt_ram.sv
sv/ptrt_div.sv
sv/ptrt_dp.sv
sv/ptrt_ctrl.sv
sv/periodic_task_release_table_unit.sv
sv/ptrt_chk.sv
test/periodic_task_release_table_unit_tb.sv
